### design/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg: shared types and constants of the set-associative tag store
// Sizes, configuration register indexes, payload structs, way and row
// records, and the rank aging function used by the way unit.
// ----------------------------------------------------------------------------
package sact_pkg;

    // Sizes of the store.
    localparam int MAX_WAYS     = 8;
    localparam int MAX_SETS     = 256;
    localparam int ADDR_WIDTH   = 48;
    localparam int CNT_W        = 48;

    localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int RANK_W       = WAY_IDX_W;
    localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_IDX_W    = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int SHIFT_W      = $clog2(15 + SET_BITS_MAX + 1);

    // Configuration port.
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE  = 2'd3;

    localparam logic       MODE_FIFO          = 1'b0;
    localparam logic       MODE_LRU           = 1'b1;
    localparam logic       RST_REPLACE_MODE   = MODE_LRU;
    localparam logic [3:0] RST_OFFSET_BITS    = 4'd6;
    localparam logic [3:0] RST_SET_BITS       = 4'd4;
    localparam logic [3:0] RST_WAYS_IN_USE    = 4'd4;

    // Payload of one access transaction.
    typedef struct packed {
        logic                  kind;
        logic [ADDR_WIDTH-1:0] address;
    } access_t;

    // Payload of one result transaction.
    typedef struct packed {
        logic             hit;
        logic             mem_write;
        logic [CNT_W-1:0] read_count;
        logic [CNT_W-1:0] write_count;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
    } result_t;

    // One way of a set, and one full set row as stored in the RAM.
    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] tag;
        logic [RANK_W-1:0]     ins_rank;
        logic [RANK_W-1:0]     rec_rank;
    } way_t;

    typedef way_t [MAX_WAYS-1:0] row_t;

    // Row RAM request.
    typedef struct packed {
        logic                 re;
        logic [SET_IDX_W-1:0] raddr;
        logic                 we;
        logic [SET_IDX_W-1:0] waddr;
        row_t                 wdata;
    } ram_req_t;

    // What the way unit needs to know about the current access.
    typedef struct packed {
        logic                  mode;
        logic [ADDR_WIDTH-1:0] tag;
        logic                  hit;
        logic [WAY_IDX_W-1:0]  hit_way;
        logic [RANK_W-1:0]     hit_rank;
        logic                  fill;
        logic [WAY_IDX_W-1:0]  fill_way;
        logic [WAY_IDX_W-1:0]  victim;
        logic [RANK_W-1:0]     vic_ins;
        logic [RANK_W-1:0]     vic_rec;
    } way_ctx_t;

    // What the way unit reports for the way it is given.
    typedef struct packed {
        logic              match;
        logic [RANK_W-1:0] order_rank;
        way_t              upd;
    } way_res_t;

    // Ages a rank by one, saturating at the oldest rank.
    function automatic logic [RANK_W-1:0] age_one(input logic [RANK_W-1:0] r);
        if (r >= RANK_W'(MAX_WAYS - 1))
            return RANK_W'(MAX_WAYS - 1);
        else
            return r + RANK_W'(1);
    endfunction

endpackage

### design/sact_row_ram.sv
// ----------------------------------------------------------------------------
// sact_row_ram: set row memory
// One row per set holding every way's valid bit, tag and ranks. One write
// port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sact_row_ram (
    input  logic               clk,
    input  sact_pkg::ram_req_t req,
    output sact_pkg::row_t     rdata
);

    sact_pkg::row_t mem [sact_pkg::MAX_SETS];
    sact_pkg::row_t rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/sact_way_unit.sv
// ----------------------------------------------------------------------------
// sact_way_unit: shared per-way compare and update unit
// Works on one way per cycle: tag compare and replacement order rank while
// the set is scanned, then the new valid bit, tag and ranks of that way.
// ----------------------------------------------------------------------------
module sact_way_unit (
    input  sact_pkg::way_t                  entry,
    input  logic [sact_pkg::WAY_IDX_W-1:0]  way,
    input  sact_pkg::way_ctx_t              ctx,
    output sact_pkg::way_res_t              res
);

    sact_pkg::way_t upd;

    // Scan outputs: tag match and rank in the chosen replacement order.
    assign res.match      = entry.valid && (entry.tag == ctx.tag);
    assign res.order_rank = (ctx.mode == sact_pkg::MODE_LRU) ? entry.rec_rank
                                                             : entry.ins_rank;

    // Update of this way for a hit, a fill of a free way, or a replacement.
    always_comb
    begin
        upd = entry;
        if (ctx.hit)
        begin
            if (way == ctx.hit_way)
            begin
                upd.rec_rank = '0;
            end
            else if (entry.valid && (entry.rec_rank < ctx.hit_rank))
            begin
                upd.rec_rank = sact_pkg::age_one(entry.rec_rank);
            end
        end
        else if (ctx.fill)
        begin
            if (way == ctx.fill_way)
            begin
                upd.valid    = 1'b1;
                upd.tag      = ctx.tag;
                upd.ins_rank = '0;
                upd.rec_rank = '0;
            end
            else if (entry.valid)
            begin
                upd.ins_rank = sact_pkg::age_one(entry.ins_rank);
                upd.rec_rank = sact_pkg::age_one(entry.rec_rank);
            end
        end
        else
        begin
            if (way == ctx.victim)
            begin
                upd.tag      = ctx.tag;
                upd.ins_rank = '0;
                upd.rec_rank = '0;
            end
            else
            begin
                if (entry.ins_rank < ctx.vic_ins)
                begin
                    upd.ins_rank = sact_pkg::age_one(entry.ins_rank);
                end
                if (entry.rec_rank < ctx.vic_rec)
                begin
                    upd.rec_rank = sact_pkg::age_one(entry.rec_rank);
                end
            end
        end
    end

    assign res.upd = upd;

endmodule

### design/sact_ctrl.sv
// ----------------------------------------------------------------------------
// sact_ctrl: access sequencer
// Holds the configuration and counters, splits the address, reads the set
// row, walks the ways through the shared way unit twice (scan, then
// update), writes the row back and issues the result.
// ----------------------------------------------------------------------------
module sact_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sact_pkg::access_t                 access,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sact_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              done,
    output sact_pkg::result_t                 result,
    output sact_pkg::ram_req_t                ram_req,
    input  sact_pkg::row_t                    ram_rdata,
    output sact_pkg::way_t                    unit_entry,
    output logic [sact_pkg::WAY_IDX_W-1:0]    unit_way,
    output sact_pkg::way_ctx_t                unit_ctx,
    input  sact_pkg::way_res_t                unit_res
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_WRITE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic       mode_reg;
    logic [3:0] offset_reg;
    logic [3:0] set_bits_reg;
    logic [3:0] ways_reg;

    // Running counters and result.
    logic [sact_pkg::CNT_W-1:0] reads_reg, writes_reg, hits_reg, misses_reg;
    logic [sact_pkg::CNT_W-1:0] reads_next, writes_next, hits_next, misses_next;
    logic                       done_reg;
    sact_pkg::result_t          result_reg;

    // Per-set flag: row has been written since reset.
    logic row_init_reg [sact_pkg::MAX_SETS];
    logic init_q_reg;

    // Access context.
    logic                               kind_reg;
    logic [sact_pkg::ADDR_WIDTH-1:0]    tag_reg;
    logic [sact_pkg::SET_IDX_W-1:0]     set_reg;
    logic [sact_pkg::WAY_CNT_W-1:0]     n_reg;
    logic [sact_pkg::WAY_IDX_W-1:0]     w_reg;
    sact_pkg::row_t                     row_reg;
    sact_pkg::row_t                     load_row;

    // Scan results.
    logic                               hit_reg;
    logic [sact_pkg::WAY_IDX_W-1:0]     hit_way_reg;
    logic [sact_pkg::RANK_W-1:0]        hit_rank_reg;
    logic                               fill_reg;
    logic [sact_pkg::WAY_IDX_W-1:0]     fill_way_reg;
    logic [sact_pkg::RANK_W-1:0]        best_reg;
    logic [sact_pkg::WAY_IDX_W-1:0]     victim_reg;
    logic [sact_pkg::RANK_W-1:0]        vic_ins_reg;
    logic [sact_pkg::RANK_W-1:0]        vic_rec_reg;

    // Address split and effective configuration.
    logic                               accept;
    logic [3:0]                         sb_eff;
    logic [sact_pkg::SHIFT_W-1:0]       tag_shift;
    logic [sact_pkg::SET_IDX_W-1:0]     set_mask;
    logic [sact_pkg::ADDR_WIDTH-1:0]    tag_in;
    logic [sact_pkg::SET_IDX_W-1:0]     set_in;
    logic [sact_pkg::WAY_CNT_W-1:0]     n_in;
    logic                               last_way;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Set count saturates to what fits in the store; way count to 1..MAX_WAYS.
    always_comb
    begin
        if (set_bits_reg > 4'(sact_pkg::SET_BITS_MAX))
            sb_eff = 4'(sact_pkg::SET_BITS_MAX);
        else
            sb_eff = set_bits_reg;

        if (ways_reg == 4'd0)
            n_in = sact_pkg::WAY_CNT_W'(1);
        else if (32'(ways_reg) > sact_pkg::MAX_WAYS)
            n_in = sact_pkg::WAY_CNT_W'(sact_pkg::MAX_WAYS);
        else
            n_in = sact_pkg::WAY_CNT_W'(ways_reg);
    end

    assign tag_shift = sact_pkg::SHIFT_W'(offset_reg) + sact_pkg::SHIFT_W'(sb_eff);
    assign tag_in    = access.address >> tag_shift;
    assign set_mask  = (sact_pkg::SET_IDX_W'(1) << sb_eff) - sact_pkg::SET_IDX_W'(1);
    assign set_in    = sact_pkg::SET_IDX_W'(access.address >> offset_reg) & set_mask;

    assign last_way  = (sact_pkg::WAY_CNT_W'(w_reg) == (n_reg - sact_pkg::WAY_CNT_W'(1)));

    // A set never written since reset reads as all ways free with zero ranks.
    assign load_row  = init_q_reg ? ram_rdata : '0;

    // Shared way unit hookup.
    assign unit_entry       = row_reg[w_reg];
    assign unit_way         = w_reg;
    assign unit_ctx.mode     = mode_reg;
    assign unit_ctx.tag      = tag_reg;
    assign unit_ctx.hit      = hit_reg;
    assign unit_ctx.hit_way  = hit_way_reg;
    assign unit_ctx.hit_rank = hit_rank_reg;
    assign unit_ctx.fill     = fill_reg;
    assign unit_ctx.fill_way = fill_way_reg;
    assign unit_ctx.victim   = victim_reg;
    assign unit_ctx.vic_ins  = vic_ins_reg;
    assign unit_ctx.vic_rec  = vic_rec_reg;

    // Row RAM requests.
    assign ram_req.re    = (state_reg == ST_READ);
    assign ram_req.raddr = set_reg;
    assign ram_req.we    = (state_reg == ST_WRITE);
    assign ram_req.waddr = set_reg;
    assign ram_req.wdata = row_reg;

    // Counter values after this access.
    always_comb
    begin
        hits_next   = hits_reg + sact_pkg::CNT_W'(hit_reg);
        misses_next = misses_reg + sact_pkg::CNT_W'(!hit_reg);
        reads_next  = reads_reg + sact_pkg::CNT_W'(!hit_reg);
        writes_next = writes_reg + sact_pkg::CNT_W'(kind_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_READ;
            ST_READ:   state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_SCAN;
            ST_SCAN:   if (last_way) state_next = ST_UPDATE;
            ST_UPDATE: if (last_way) state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration, counters and set flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= sact_pkg::RST_REPLACE_MODE;
            offset_reg   <= sact_pkg::RST_OFFSET_BITS;
            set_bits_reg <= sact_pkg::RST_SET_BITS;
            ways_reg     <= sact_pkg::RST_WAYS_IN_USE;
            reads_reg    <= '0;
            writes_reg   <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < sact_pkg::MAX_SETS; i++)
            begin
                row_init_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WRITE);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sact_pkg::REG_REPLACE_MODE: mode_reg     <= cfg_data[0];
                    sact_pkg::REG_OFFSET_BITS:  offset_reg   <= cfg_data[3:0];
                    sact_pkg::REG_SET_BITS:     set_bits_reg <= cfg_data[3:0];
                    sact_pkg::REG_WAYS_IN_USE:  ways_reg     <= cfg_data[3:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_WRITE)
            begin
                reads_reg             <= reads_next;
                writes_reg            <= writes_next;
                hits_reg              <= hits_next;
                misses_reg            <= misses_next;
                row_init_reg[set_reg] <= 1'b1;
            end
        end
    end

    // Access datapath: context, row copy, scan and update of the ways.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_reg <= access.kind;
                    tag_reg  <= tag_in;
                    set_reg  <= set_in;
                    n_reg    <= n_in;
                end
            end
            ST_READ:
            begin
                init_q_reg <= row_init_reg[set_reg];
            end
            ST_LOAD:
            begin
                row_reg     <= load_row;
                w_reg       <= '0;
                hit_reg     <= 1'b0;
                fill_reg    <= 1'b0;
                best_reg    <= '0;
                victim_reg  <= '0;
                vic_ins_reg <= load_row[0].ins_rank;
                vic_rec_reg <= load_row[0].rec_rank;
            end
            ST_SCAN:
            begin
                // First matching way is the hit way.
                if (unit_res.match && !hit_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_way_reg  <= w_reg;
                    hit_rank_reg <= unit_entry.rec_rank;
                end
                // Lowest free way is the fill target.
                if (!unit_entry.valid && !fill_reg)
                begin
                    fill_reg     <= 1'b1;
                    fill_way_reg <= w_reg;
                end
                // Lowest way of greatest rank is the victim.
                if (unit_res.order_rank > best_reg)
                begin
                    best_reg    <= unit_res.order_rank;
                    victim_reg  <= w_reg;
                    vic_ins_reg <= unit_entry.ins_rank;
                    vic_rec_reg <= unit_entry.rec_rank;
                end
                w_reg <= last_way ? '0 : w_reg + sact_pkg::WAY_IDX_W'(1);
            end
            ST_UPDATE:
            begin
                row_reg[w_reg] <= unit_res.upd;
                w_reg          <= w_reg + sact_pkg::WAY_IDX_W'(1);
            end
            ST_WRITE:
            begin
                result_reg.hit         <= hit_reg;
                result_reg.mem_write   <= kind_reg;
                result_reg.read_count  <= reads_next;
                result_reg.write_count <= writes_next;
                result_reg.hit_count   <= hits_next;
                result_reg.miss_count  <= misses_next;
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/set_assoc_cache_tag_store.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store: set-associative cache tag store
// Looks up each access in its set, fills or replaces a way on a miss (FIFO
// or LRU order) and reports hit, memory write and four running counters.
//
// Access channel: an access transaction (kind, address) is taken at a rising
// edge with start high and busy low; busy stays high until the set row has
// been written back, and falls in the cycle the result is shown.
// Result channel: done is high for exactly one cycle with result valid. The
// receiver cannot stall; the result must be taken in that cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while busy is low.
// Sequencing: with n ways in use, the block steps through row read, row load,
// a scan of the n ways through the single way unit, an update of the n ways
// and write-back, then raises done. Accesses are handled one at a time; the
// next access can be taken at the edge that ends the done cycle.
// Reset: counters clear, configuration returns to LRU, 64-byte blocks, 16
// sets, 4 ways; every set reads as empty until first written, so an access
// can start right after reset.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sact_pkg::access_t                 access,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sact_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              done,
    output sact_pkg::result_t                 result
);

    sact_pkg::ram_req_t                 ram_req;
    sact_pkg::row_t                     ram_rdata;
    sact_pkg::way_t                     unit_entry;
    logic [sact_pkg::WAY_IDX_W-1:0]     unit_way;
    sact_pkg::way_ctx_t                 unit_ctx;
    sact_pkg::way_res_t                 unit_res;

    // Sequencer, configuration and counters.
    sact_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .access     (access),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .result     (result),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .unit_entry (unit_entry),
        .unit_way   (unit_way),
        .unit_ctx   (unit_ctx),
        .unit_res   (unit_res)
    );

    // Shared per-way compare and update unit.
    sact_way_unit u_way (
        .entry (unit_entry),
        .way   (unit_way),
        .ctx   (unit_ctx),
        .res   (unit_res)
    );

    // Set row storage.
    sact_row_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

### design/sact_checker.sv
// ----------------------------------------------------------------------------
// sact_checker: port-level checks of the tag store
// Watches the access and result ports for sequencing slips.
// ----------------------------------------------------------------------------
module sact_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  sact_pkg::result_t result
);

    // An accepted transaction makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted access");

    // A result never appears in the cycle right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result issued too early");

    // The result strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A result is issued only once the block is free again.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // Every miss is one memory read, so the two counters always agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.read_count == result.miss_count))
        else $error("read and miss counters disagree");

endmodule

bind set_assoc_cache_tag_store sact_checker u_sact_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### dv/tag_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_store_checker: result checker for the set-associative tag store
// Watches the access, configuration and result channels. Every accepted
// access is run through a local model of the tag store to predict its
// result, and every result the block shows is compared field by field with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tag_store_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  sact_pkg::access_t               access,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            done,
    input  sact_pkg::result_t               result,
    output int                              mismatch_count,
    output int                              outcomes_waiting
);

    localparam int DEPTH = sact_pkg::MAX_WAYS * sact_pkg::MAX_SETS;
    localparam logic [sact_pkg::RANK_W-1:0] OLDEST_RANK =
        sact_pkg::RANK_W'(sact_pkg::MAX_WAYS - 1);
    localparam int PRINT_LIMIT = 100;

    // Model copy of the way store, indexed by set * MAX_WAYS + way.
    logic                            way_live  [DEPTH];
    logic [sact_pkg::ADDR_WIDTH-1:0] way_label [DEPTH];
    logic [sact_pkg::RANK_W-1:0]     fill_age  [DEPTH];
    logic [sact_pkg::RANK_W-1:0]     use_age   [DEPTH];

    // Model copy of the running counters and the configuration.
    logic [sact_pkg::CNT_W-1:0] reads_seen;
    logic [sact_pkg::CNT_W-1:0] writes_seen;
    logic [sact_pkg::CNT_W-1:0] hits_seen;
    logic [sact_pkg::CNT_W-1:0] misses_seen;
    logic                       mode_cfg;
    logic [3:0]                 offset_cfg;
    logic [3:0]                 set_bits_cfg;
    logic [3:0]                 ways_cfg;

    // Predicted results of accesses whose result has not been shown yet.
    sact_pkg::result_t predicted_outcomes[$];
    sact_pkg::result_t oldest_outcome;
    sact_pkg::result_t new_outcome;

    // Rank one step older, saturating at the oldest rank.
    function automatic logic [sact_pkg::RANK_W-1:0] one_older(
        input logic [sact_pkg::RANK_W-1:0] r);
        return (r >= OLDEST_RANK) ? OLDEST_RANK : r + sact_pkg::RANK_W'(1);
    endfunction

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string what,
                                   input logic [sact_pkg::CNT_W-1:0] got,
                                   input logic [sact_pkg::CNT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        end
    endtask

    // Looks up one access in the model store, updates ranks and counters, and
    // returns the result the block should report.
    task automatic lookup_and_update(input sact_pkg::access_t acc,
                                     output sact_pkg::result_t outcome);
        int unsigned                 nways;
        int unsigned                 sbits;
        int unsigned                 base;
        int unsigned                 hit_way;
        int unsigned                 victim;
        logic [63:0]                 addr64;
        logic [63:0]                 set_idx;
        logic [63:0]                 tag64;
        logic                        found;
        logic                        filled;
        logic [sact_pkg::RANK_W-1:0] hit_age;
        logic [sact_pkg::RANK_W-1:0] best;
        logic [sact_pkg::RANK_W-1:0] order_age;
        logic [sact_pkg::RANK_W-1:0] victim_fill;
        logic [sact_pkg::RANK_W-1:0] victim_use;

        // Zero ways acts as one; too many ways are capped.
        nways = 32'(ways_cfg);
        if (nways == 0)
            nways = 1;
        if (nways > sact_pkg::MAX_WAYS)
            nways = sact_pkg::MAX_WAYS;

        // The set count is saturated to what the store holds.
        sbits = 32'(set_bits_cfg);
        while (sbits > 0 && (64'd1 << sbits) > 64'(sact_pkg::MAX_SETS))
            sbits--;

        addr64  = 64'(acc.address);
        set_idx = (addr64 >> offset_cfg) & ((64'd1 << sbits) - 64'd1);
        tag64   = addr64 >> (offset_cfg + sbits);
        base    = int'(set_idx) * sact_pkg::MAX_WAYS;

        // Tag search over the ways in use; only valid ways are compared.
        found   = 1'b0;
        hit_way = 0;
        for (int w = 0; w < nways; w++)
        begin
            if (!found && way_live[base + w]
                && way_label[base + w] == tag64[sact_pkg::ADDR_WIDTH-1:0])
            begin
                found   = 1'b1;
                hit_way = w;
            end
        end

        if (found)
        begin
            // Hit: ways used more recently than the hit way age by one.
            hit_age = use_age[base + hit_way];
            for (int w = 0; w < nways; w++)
            begin
                if (w != hit_way && way_live[base + w] && use_age[base + w] < hit_age)
                    use_age[base + w] = one_older(use_age[base + w]);
            end
            use_age[base + hit_way] = '0;
            hits_seen++;
        end
        else
        begin
            misses_seen++;
            reads_seen++;

            // Miss with a free way: the lowest invalid way is filled.
            filled = 1'b0;
            for (int w = 0; w < nways; w++)
            begin
                if (!filled && !way_live[base + w])
                begin
                    for (int v = 0; v < nways; v++)
                    begin
                        if (way_live[base + v])
                        begin
                            fill_age[base + v] = one_older(fill_age[base + v]);
                            use_age[base + v]  = one_older(use_age[base + v]);
                        end
                    end
                    way_live[base + w]  = 1'b1;
                    way_label[base + w] = tag64[sact_pkg::ADDR_WIDTH-1:0];
                    fill_age[base + w]  = '0;
                    use_age[base + w]   = '0;
                    filled = 1'b1;
                end
            end

            // Full set: the lowest way of greatest rank in the chosen order goes.
            if (!filled)
            begin
                best   = '0;
                victim = 0;
                for (int w = 0; w < nways; w++)
                begin
                    order_age = (mode_cfg == sact_pkg::MODE_LRU) ? use_age[base + w]
                                                                 : fill_age[base + w];
                    if (order_age > best)
                    begin
                        best   = order_age;
                        victim = w;
                    end
                end
                victim_fill = fill_age[base + victim];
                victim_use  = use_age[base + victim];
                for (int w = 0; w < nways; w++)
                begin
                    if (w != victim)
                    begin
                        if (fill_age[base + w] < victim_fill)
                            fill_age[base + w] = one_older(fill_age[base + w]);
                        if (use_age[base + w] < victim_use)
                            use_age[base + w] = one_older(use_age[base + w]);
                    end
                end
                way_label[base + victim] = tag64[sact_pkg::ADDR_WIDTH-1:0];
                fill_age[base + victim]  = '0;
                use_age[base + victim]   = '0;
            end
        end

        if (acc.kind)
            writes_seen++;

        outcome.hit         = found;
        outcome.mem_write   = acc.kind;
        outcome.read_count  = reads_seen;
        outcome.write_count = writes_seen;
        outcome.hit_count   = hits_seen;
        outcome.miss_count  = misses_seen;
    endtask

    // Channel monitor: retire results, track register writes, predict accesses.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                way_live[i]  = 1'b0;
                way_label[i] = '0;
                fill_age[i]  = '0;
                use_age[i]   = '0;
            end
            reads_seen   = '0;
            writes_seen  = '0;
            hits_seen    = '0;
            misses_seen  = '0;
            mode_cfg     = sact_pkg::RST_REPLACE_MODE;
            offset_cfg   = sact_pkg::RST_OFFSET_BITS;
            set_bits_cfg = sact_pkg::RST_SET_BITS;
            ways_cfg     = sact_pkg::RST_WAYS_IN_USE;
            predicted_outcomes.delete();
            mismatch_count = 0;
            outcomes_waiting <= 0;
        end
        else
        begin
            // A shown result is compared with the oldest prediction.
            if (done)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    report_mismatch("result with no access waiting", result.read_count, '0);
                end
                else
                begin
                    oldest_outcome = predicted_outcomes.pop_front();
                    if (result.hit !== oldest_outcome.hit)
                        report_mismatch("hit", sact_pkg::CNT_W'(result.hit),
                                        sact_pkg::CNT_W'(oldest_outcome.hit));
                    if (result.mem_write !== oldest_outcome.mem_write)
                        report_mismatch("mem_write", sact_pkg::CNT_W'(result.mem_write),
                                        sact_pkg::CNT_W'(oldest_outcome.mem_write));
                    if (result.read_count !== oldest_outcome.read_count)
                        report_mismatch("read_count", result.read_count,
                                        oldest_outcome.read_count);
                    if (result.write_count !== oldest_outcome.write_count)
                        report_mismatch("write_count", result.write_count,
                                        oldest_outcome.write_count);
                    if (result.hit_count !== oldest_outcome.hit_count)
                        report_mismatch("hit_count", result.hit_count, oldest_outcome.hit_count);
                    if (result.miss_count !== oldest_outcome.miss_count)
                        report_mismatch("miss_count", result.miss_count,
                                        oldest_outcome.miss_count);
                end
            end

            // Register write transaction.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sact_pkg::REG_REPLACE_MODE: mode_cfg     = cfg_data[0];
                    sact_pkg::REG_OFFSET_BITS:  offset_cfg   = cfg_data;
                    sact_pkg::REG_SET_BITS:     set_bits_cfg = cfg_data;
                    sact_pkg::REG_WAYS_IN_USE:  ways_cfg     = cfg_data;
                    default:                    ;
                endcase
            end

            // Accepted access transaction.
            if (start && !busy)
            begin
                lookup_and_update(access, new_outcome);
                predicted_outcomes.push_back(new_outcome);
            end

            outcomes_waiting <= predicted_outcomes.size();
        end
    end

endmodule

### dv/tb_set_assoc_cache_tag_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_store: testbench top for the cache tag store
// Drives a short directed sequence of fills, hits and evictions in both
// replacement modes, then phases of random accesses under a range of
// configurations, with bursts and gaps on the access channel. Checking is
// done by the checker instance beside the block; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_store;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam int   DRAIN_CYCLES = 40;

    logic                            clk;
    logic                            rst_n;
    logic                            start     = 1'b0;
    sact_pkg::access_t               access    = '0;
    logic                            cfg_valid = 1'b0;
    logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sact_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            busy;
    logic                            cfg_ready;
    logic                            done;
    sact_pkg::result_t               result;
    int                              mismatch_count;
    int                              outcomes_waiting;

    // Stimulus-side copy of the geometry registers, used to shape addresses.
    logic [3:0] cur_offset   = sact_pkg::RST_OFFSET_BITS;
    logic [3:0] cur_set_bits = sact_pkg::RST_SET_BITS;
    logic [3:0] cur_ways     = sact_pkg::RST_WAYS_IN_USE;
    bit         sender_on    = 1'b0;

    set_assoc_cache_tag_store DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .access    (access),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    tag_store_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .access           (access),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .result           (result),
        .mismatch_count   (mismatch_count),
        .outcomes_waiting (outcomes_waiting)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Set index width actually used for the current set_bits value.
    function automatic int unsigned active_set_bits();
        int unsigned sb;
        sb = 32'(cur_set_bits);
        while (sb > 0 && (1 << sb) > sact_pkg::MAX_SETS)
            sb--;
        return sb;
    endfunction

    // Builds a byte address from tag, set and block offset.
    function automatic logic [sact_pkg::ADDR_WIDTH-1:0] compose_address(
        input logic [63:0] tag, input int unsigned set_no, input logic [63:0] offs);
        int unsigned sb;
        logic [63:0] addr;
        sb   = active_set_bits();
        addr = (tag << (cur_offset + sb))
             | ((64'(set_no) & ((64'd1 << sb) - 64'd1)) << cur_offset)
             | (offs & ((64'd1 << cur_offset) - 64'd1));
        return addr[sact_pkg::ADDR_WIDTH-1:0];
    endfunction

    function automatic sact_pkg::access_t make_access(
        input logic kind, input logic [sact_pkg::ADDR_WIDTH-1:0] addr);
        sact_pkg::access_t item;
        item.kind    = kind;
        item.address = addr;
        return item;
    endfunction

    // Random access: mostly a small pool of tags on a few hot sets so that
    // sets fill, hit and evict; the rest is random addresses.
    function automatic sact_pkg::access_t pick_access();
        int unsigned       sb;
        int unsigned       ways_eff;
        int unsigned       hot;
        int unsigned       pick;
        int unsigned       set_no;
        logic [63:0]       tag;
        sact_pkg::access_t item;
        sb       = active_set_bits();
        ways_eff = 32'(cur_ways);
        if (ways_eff == 0)
            ways_eff = 1;
        if (ways_eff > sact_pkg::MAX_WAYS)
            ways_eff = sact_pkg::MAX_WAYS;
        hot      = (sb >= 2) ? 4 : (1 << sb);
        pick     = $urandom_range(0, 99);
        item.kind = ($urandom_range(0, 1) == 1) ? KIND_WRITE : KIND_READ;
        if (pick < 80)
        begin
            set_no = (pick < 12) ? $urandom : $urandom_range(0, hot - 1);
            tag    = (pick < 6) ? {$urandom, $urandom} : 64'($urandom_range(0, ways_eff + 2));
            item.address = compose_address(tag, set_no, {$urandom, $urandom});
        end
        else
        begin
            item.address = sact_pkg::ADDR_WIDTH'({$urandom, $urandom});
        end
        return item;
    endfunction

    // Presents one access and returns at the edge where it is accepted.
    task automatic issue(input sact_pkg::access_t item);
        access    <= item;
        start     <= 1'b1;
        sender_on = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // Lowers start, once, and idles the access channel.
    task automatic hold_sender(input int cycles);
        if (sender_on)
        begin
            start     <= 1'b0;
            sender_on = 1'b0;
        end
        repeat (cycles) @(posedge clk);
    endtask

    // Waits until every predicted result has been shown and the block is idle.
    task automatic settle();
        hold_sender(1);
        while (outcomes_waiting != 0 || busy)
            @(posedge clk);
    endtask

    // One register write transaction; cfg_valid is left high for the caller.
    task automatic program_register(input logic [sact_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [sact_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            sact_pkg::REG_OFFSET_BITS: cur_offset   = data;
            sact_pkg::REG_SET_BITS:    cur_set_bits = data;
            sact_pkg::REG_WAYS_IN_USE: cur_ways     = data;
            default:                   ;
        endcase
    endtask

    // Reconfigures the idle block, then sends random accesses in bursts.
    // Halfway through, the sender waits for every result to come back.
    task automatic run_phase(input logic mode, input logic [3:0] ob, input logic [3:0] sb,
                             input logic [3:0] ways, input int items);
        int burst_left;
        settle();
        program_register(sact_pkg::REG_REPLACE_MODE, {3'($urandom_range(0, 7)), mode});
        program_register(sact_pkg::REG_OFFSET_BITS, ob);
        program_register(sact_pkg::REG_SET_BITS, sb);
        program_register(sact_pkg::REG_WAYS_IN_USE, ways);
        cfg_valid <= 1'b0;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
                settle();
            issue(pick_access());
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                hold_sender($urandom_range(1, 30));
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // LRU at reset geometry: fill set 0, hit, evict the least recently used.
        issue(make_access(KIND_READ,  compose_address(0, 0, 0)));
        issue(make_access(KIND_READ,  compose_address(0, 0, 63)));
        issue(make_access(KIND_WRITE, compose_address(0, 0, 0)));
        issue(make_access(KIND_READ,  compose_address(1, 0, 0)));
        issue(make_access(KIND_READ,  compose_address(2, 0, 5)));
        issue(make_access(KIND_WRITE, compose_address(3, 0, 0)));
        issue(make_access(KIND_READ,  compose_address(0, 0, 0)));
        issue(make_access(KIND_WRITE, compose_address(4, 0, 0)));
        issue(make_access(KIND_READ,  compose_address(1, 0, 0)));
        issue(make_access(KIND_READ,  compose_address(3, 0, 0)));

        // Address extremes.
        issue(make_access(KIND_READ,  '1));
        issue(make_access(KIND_WRITE, '1));
        issue(make_access(KIND_WRITE, compose_address(0, 15, 0)));
        issue(make_access(KIND_READ,  compose_address('1, 0, 0)));

        // FIFO: a recent hit does not save the first inserted way.
        settle();
        program_register(sact_pkg::REG_REPLACE_MODE, {3'b000, sact_pkg::MODE_FIFO});
        cfg_valid <= 1'b0;
        issue(make_access(KIND_READ,  compose_address(0, 1, 0)));
        issue(make_access(KIND_READ,  compose_address(1, 1, 0)));
        issue(make_access(KIND_READ,  compose_address(2, 1, 0)));
        issue(make_access(KIND_READ,  compose_address(3, 1, 0)));
        issue(make_access(KIND_READ,  compose_address(0, 1, 0)));
        issue(make_access(KIND_WRITE, compose_address(5, 1, 0)));
        issue(make_access(KIND_READ,  compose_address(0, 1, 0)));
        issue(make_access(KIND_READ,  compose_address(1, 1, 0)));

        // Random phases: reset geometry, smallest geometry, largest legal
        // geometry, saturated sets and ways with a large offset, zero ways,
        // then shrinking and growing the ways in use over stale entries.
        run_phase(sact_pkg::MODE_FIFO, 4'd6,  4'd4,  4'd4,  130);
        run_phase(sact_pkg::MODE_LRU,  4'd0,  4'd0,  4'd1,  100);
        run_phase(sact_pkg::MODE_FIFO, 4'd12, 4'd8,  4'd8,  150);
        run_phase(sact_pkg::MODE_LRU,  4'd15, 4'd15, 4'd15, 120);
        run_phase(sact_pkg::MODE_LRU,  4'd3,  4'd2,  4'd0,  90);
        run_phase(sact_pkg::MODE_FIFO, 4'd4,  4'd1,  4'd8,  130);
        run_phase(sact_pkg::MODE_LRU,  4'd4,  4'd1,  4'd2,  130);
        run_phase(sact_pkg::MODE_LRU,  4'd4,  4'd1,  4'd8,  130);
        run_phase(sact_pkg::MODE_FIFO, 4'd0,  4'd8,  4'd3,  120);
        run_phase(sact_pkg::MODE_LRU,  4'd9,  4'd5,  4'd7,  150);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
